[rtl/bbq_pkg.sv]
// Shared types, constants and the saturating adder of the three-axis biquad.
// Used by every other file of the block; depends on nothing.
package bbq_pkg;

  // Fixed geometry: one lane per sensor axis, 64-bit symmetric accumulator
  localparam int AXES            = 3;
  localparam int ACC_W           = 64;
  localparam int COEF_W          = 32;
  localparam int B0_W            = 31;
  localparam int DELAY_FRAC      = 16;
  localparam int SH_GAIN         = 24;
  localparam int SH_COEF         = 30;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int DELAY_BITS_DEF  = 40;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd4;

  // Sequencer states, shared by the controller and the lanes.
  // xMA latches operands, xM0/xM1 take the two partial products, xM2 sums.
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
  localparam logic [ST_W-1:0] ST_PMA  = 5'd1;   // preload: sample * gain
  localparam logic [ST_W-1:0] ST_PM0  = 5'd2;
  localparam logic [ST_W-1:0] ST_PM1  = 5'd3;
  localparam logic [ST_W-1:0] ST_PM2  = 5'd4;
  localparam logic [ST_W-1:0] ST_PST  = 5'd5;   // store preload into delays
  localparam logic [ST_W-1:0] ST_AMA  = 5'd6;   // d1 * a1
  localparam logic [ST_W-1:0] ST_AM0  = 5'd7;
  localparam logic [ST_W-1:0] ST_AM1  = 5'd8;
  localparam logic [ST_W-1:0] ST_AM2  = 5'd9;
  localparam logic [ST_W-1:0] ST_W1   = 5'd10;  // w = s - a1*d1
  localparam logic [ST_W-1:0] ST_BMA  = 5'd11;  // d2 * a2
  localparam logic [ST_W-1:0] ST_BM0  = 5'd12;
  localparam logic [ST_W-1:0] ST_BM1  = 5'd13;
  localparam logic [ST_W-1:0] ST_BM2  = 5'd14;
  localparam logic [ST_W-1:0] ST_W2   = 5'd15;  // w -= a2*d2, clip to delay
  localparam logic [ST_W-1:0] ST_S1   = 5'd16;  // acc = w + 2*d1
  localparam logic [ST_W-1:0] ST_S2   = 5'd17;  // acc += d2, shift delays
  localparam logic [ST_W-1:0] ST_CMA  = 5'd18;  // acc * b0
  localparam logic [ST_W-1:0] ST_CM0  = 5'd19;
  localparam logic [ST_W-1:0] ST_CM1  = 5'd20;
  localparam logic [ST_W-1:0] ST_CM2  = 5'd21;
  localparam logic [ST_W-1:0] ST_RND  = 5'd22;  // add rounding half
  localparam logic [ST_W-1:0] ST_HAND = 5'd23;  // hand result to merge stage

  typedef struct packed {
    logic [B0_W-1:0]   b0;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] gain;
  } bbq_coef_t;

  typedef struct packed {
    logic [ST_W-1:0] state;
    logic            load;
    logic            filt;
  } bbq_ctrl_t;

  typedef struct packed {
    logic             clip;
    logic [ACC_W-1:0] val;
  } bbq_sat_t;

  // a + b or a - b, clipped to the symmetric range [-lim, lim]
  function automatic bbq_sat_t bbq_addsub(input logic signed [ACC_W-1:0] a,
                                          input logic signed [ACC_W-1:0] b,
                                          input logic                    sub,
                                          input logic [ACC_W-1:0]        lim);
    logic signed [ACC_W+1:0] ax;
    logic signed [ACC_W+1:0] bx;
    logic signed [ACC_W+1:0] sum;
    logic signed [ACC_W+1:0] hi;
    logic signed [ACC_W+1:0] lo;
    bbq_sat_t                r;
    ax  = (ACC_W+2)'(a);
    bx  = (ACC_W+2)'(b);
    hi  = (ACC_W+2)'(lim);
    lo  = -hi;
    sum = ax + (sub ? ~bx : bx) + (ACC_W+2)'(sub);
    if (sum > hi) begin
      r = {1'b1, lim};
    end else if (sum < lo) begin
      r = {1'b1, lo[ACC_W-1:0]};
    end else begin
      r = {1'b0, sum[ACC_W-1:0]};
    end
    return r;
  endfunction

endpackage

[rtl/bbq_if.sv]
// Valid/ready channel interfaces for samples in and filtered results out.
// Depends on bbq_pkg for default widths.
interface bbq_in_if import bbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, kind, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, kind, sample_x, sample_y, sample_z, output ready);
endinterface

interface bbq_out_if import bbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_x;
  logic signed [SAMPLE_BITS-1:0] out_y;
  logic signed [SAMPLE_BITS-1:0] out_z;
  logic                          saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

[rtl/butterworth_biquad_three_axis.sv]
// Three-axis second-order Butterworth low-pass biquad (direct form II), one
// lane per axis plus a shared sequencer and an output merge register.
// Depends on bbq_pkg, bbq_if, bbq_ctrl, bbq_lane and bbq_merge.
//
// Each accepted item is processed by three identical lanes in lockstep, each
// with its own 32x32 multiplier that forms every 64x32 product in two halves
// (operand latch, low half, high half, recombine). A filtered item walks the
// a1 product, the a2 product, the sums, the b0 product and the rounding before
// handoff; a preload item first forms the gain product and stores it into the
// delays, and a pass-through item (filter disabled) goes straight to handoff.
// The next item is taken in the idle cycle that follows the load of the output
// register, so no new item is taken before the last one is handed off. While
// the output register still holds a result the sink has not taken, the
// sequencer waits in handoff. The sample width is fixed to SAMPLE_BITS_DEF of
// bbq_pkg. No clearing pass is needed after reset.
module butterworth_biquad_three_axis import bbq_pkg::*; #(
  parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bbq_in_if.sink                in_ch,
  bbq_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;

  // Configuration registers
  logic              cfg_en_r;
  logic [B0_W-1:0]   cfg_b0_r;
  logic [COEF_W-1:0] cfg_a1_r;
  logic [COEF_W-1:0] cfg_a2_r;
  logic [COEF_W-1:0] cfg_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r   <= 1'b0;
      cfg_b0_r   <= '0;
      cfg_a1_r   <= '0;
      cfg_a2_r   <= '0;
      cfg_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: cfg_en_r   <= cfg_data[0];
        CFG_B0:     cfg_b0_r   <= cfg_data[B0_W-1:0];
        CFG_A1:     cfg_a1_r   <= cfg_data[COEF_W-1:0];
        CFG_A2:     cfg_a2_r   <= cfg_data[COEF_W-1:0];
        CFG_GAIN:   cfg_gain_r <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  bbq_coef_t coef;
  assign coef.b0   = cfg_b0_r;
  assign coef.a1   = cfg_a1_r;
  assign coef.a2   = cfg_a2_r;
  assign coef.gain = cfg_gain_r;

  // Sequencer
  bbq_ctrl_t ctrl_s;
  logic      in_ready;
  logic      push;
  logic      out_free;
  logic      in_accept;

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  bbq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .filt_en  (cfg_en_r),
    .out_free (out_free),
    .in_ready (in_ready),
    .push     (push),
    .ctrl     (ctrl_s)
  );

  // Axis lanes
  logic signed [SAMPLE_BITS-1:0] lane_sample [AXES];
  logic signed [SAMPLE_BITS-1:0] lane_res    [AXES];
  logic [AXES-1:0]               lane_clip;

  assign lane_sample[0] = in_ch.sample_x;
  assign lane_sample[1] = in_ch.sample_y;
  assign lane_sample[2] = in_ch.sample_z;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    bbq_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DELAY_BITS  (DELAY_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl_s),
      .coef   (coef),
      .sample (lane_sample[g]),
      .res    (lane_res[g]),
      .clip   (lane_clip[g])
    );
  end

  // Output merge register
  bbq_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .lane_res  (lane_res),
    .lane_clip (lane_clip),
    .free      (out_free),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // Pass-through item goes straight to handoff
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_ch.kind && !cfg_en_r) |=> (ctrl_s.state == ST_HAND))
    else $error("pass-through item did not go straight to handoff");

  // A handoff always shows up on the output channel
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_ch.valid)
    else $error("handoff did not raise output valid");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !push)
    else $error("output register overwritten while stalled");

  // Handoff holds until the merge stage has room
  a_hand_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_s.state == ST_HAND && !push) |=> (ctrl_s.state == ST_HAND))
    else $error("handoff left without a transfer into the output register");
`endif

endmodule

[rtl/bbq_ctrl.sv]
// Step sequencer shared by all axis lanes: walks preload, filter and handoff.
// Depends on bbq_pkg for state codes and the control struct.
module bbq_ctrl import bbq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  input  logic      filt_en,
  input  logic      out_free,
  output logic      in_ready,
  output logic      push,
  output bbq_ctrl_t ctrl
);

  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;
  logic            filt_r;
  logic            accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign push     = (state_r == ST_HAND) && out_free;

  // Next step
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind) begin
            state_nxt = ST_PMA;
          end else if (filt_en) begin
            state_nxt = ST_AMA;
          end else begin
            state_nxt = ST_HAND;
          end
        end
      end
      ST_PMA:  state_nxt = ST_PM0;
      ST_PM0:  state_nxt = ST_PM1;
      ST_PM1:  state_nxt = ST_PM2;
      ST_PM2:  state_nxt = ST_PST;
      ST_PST:  state_nxt = filt_r ? ST_AMA : ST_HAND;
      ST_AMA:  state_nxt = ST_AM0;
      ST_AM0:  state_nxt = ST_AM1;
      ST_AM1:  state_nxt = ST_AM2;
      ST_AM2:  state_nxt = ST_W1;
      ST_W1:   state_nxt = ST_BMA;
      ST_BMA:  state_nxt = ST_BM0;
      ST_BM0:  state_nxt = ST_BM1;
      ST_BM1:  state_nxt = ST_BM2;
      ST_BM2:  state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_S1;
      ST_S1:   state_nxt = ST_S2;
      ST_S2:   state_nxt = ST_CMA;
      ST_CMA:  state_nxt = ST_CM0;
      ST_CM0:  state_nxt = ST_CM1;
      ST_CM1:  state_nxt = ST_CM2;
      ST_CM2:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_HAND;
      ST_HAND: state_nxt = out_free ? ST_IDLE : ST_HAND;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      filt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        filt_r <= filt_en;
      end
    end
  end

  assign ctrl.state = state_r;
  assign ctrl.load  = accept;
  assign ctrl.filt  = filt_r;

endmodule

[rtl/bbq_lane.sv]
// One axis of the biquad: delay state, a 32x32 multiplier used in two halves,
// and one saturating adder. Depends on bbq_pkg.
module bbq_lane import bbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbq_ctrl_t                     ctrl,
  input  bbq_coef_t                     coef,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] res,
  output logic                          clip
);

  localparam int FULL_W = ACC_W + COEF_W + 1;
  localparam logic [ACC_W-1:0] DLIM =
    ACC_W'((65'd1 << (DELAY_BITS - 1)) - 65'd1);
  localparam logic signed [ACC_W-1:0] OUT_HI =
    signed'(ACC_W'((65'd1 << (SAMPLE_BITS - 1)) - 65'd1));
  localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - 1;
  localparam logic signed [ACC_W-1:0] HALF =
    signed'(ACC_W'(1) << (DELAY_FRAC - 1));

  // State and datapath registers
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [DELAY_BITS-1:0]  d1_r;
  logic signed [DELAY_BITS-1:0]  d2_r;
  logic signed [DELAY_BITS-1:0]  w_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       dd_r;
  logic [ACC_W-1:0]              mag_r;
  logic [COEF_W-1:0]             cmag_r;
  logic                          neg_r;
  logic [2*COEF_W-1:0]           prod_r;
  logic [2*COEF_W-1:0]           lo_r;
  logic [ACC_W-1:0]              t_r;
  logic                          clip_r;

  logic signed [ACC_W-1:0] sq;
  logic signed [ACC_W-1:0] d1x;
  logic signed [ACC_W-1:0] d2x;
  logic is_ma, is_m0, is_m1, is_m2, sh24;

  assign sq  = ACC_W'(sample_r) <<< DELAY_FRAC;
  assign d1x = ACC_W'(d1_r);
  assign d2x = ACC_W'(d2_r);

  assign is_ma = (ctrl.state == ST_PMA) || (ctrl.state == ST_AMA) ||
                 (ctrl.state == ST_BMA) || (ctrl.state == ST_CMA);
  assign is_m0 = (ctrl.state == ST_PM0) || (ctrl.state == ST_AM0) ||
                 (ctrl.state == ST_BM0) || (ctrl.state == ST_CM0);
  assign is_m1 = (ctrl.state == ST_PM1) || (ctrl.state == ST_AM1) ||
                 (ctrl.state == ST_BM1) || (ctrl.state == ST_CM1);
  assign is_m2 = (ctrl.state == ST_PM2) || (ctrl.state == ST_AM2) ||
                 (ctrl.state == ST_BM2) || (ctrl.state == ST_CM2);
  assign sh24  = (ctrl.state == ST_PM2);

  // Multiplier operand select
  logic signed [ACC_W-1:0] mul_v;
  logic [COEF_W-1:0]       mul_c;
  logic                    mul_cneg;
  logic [ACC_W-1:0]        mul_mag;

  always_comb begin
    mul_v    = '0;
    mul_c    = '0;
    mul_cneg = 1'b0;
    unique case (ctrl.state)
      ST_PMA: begin
        mul_v = sq;
        mul_c = coef.gain;
      end
      ST_AMA: begin
        mul_v    = d1x;
        mul_cneg = coef.a1[COEF_W-1];
        mul_c    = mul_cneg ? -coef.a1 : coef.a1;
      end
      ST_BMA: begin
        mul_v    = d2x;
        mul_cneg = coef.a2[COEF_W-1];
        mul_c    = mul_cneg ? -coef.a2 : coef.a2;
      end
      ST_CMA: begin
        mul_v = acc_r;
        mul_c = {1'b0, coef.b0};
      end
      default: ;
    endcase
    mul_mag = mul_v[ACC_W-1] ? -mul_v : mul_v;
  end

  // Partial products: low half of the magnitude first, then the high half
  logic [COEF_W-1:0] mul_chunk;
  assign mul_chunk = is_m0 ? mag_r[COEF_W-1:0] : mag_r[ACC_W-1:COEF_W];

  // Recombine, drop the fraction bits and clip the magnitude
  logic [ACC_W:0]       hi_sum;
  logic [FULL_W-1:0]    full;
  logic                 t_clip;
  logic [ACC_W-1:0]     t_val;

  assign hi_sum = {1'b0, prod_r} + (ACC_W+1)'(lo_r[2*COEF_W-1:COEF_W]);
  assign full   = {hi_sum, lo_r[COEF_W-1:0]};
  assign t_clip = sh24 ? |full[FULL_W-1:ACC_W-1+SH_GAIN]
                       : |full[FULL_W-1:ACC_W-1+SH_COEF];
  assign t_val  = sh24 ? full[ACC_W-1+SH_GAIN:SH_GAIN]
                       : full[ACC_W-1+SH_COEF:SH_COEF];

  // Shared saturating adder operand select
  logic signed [ACC_W-1:0] add_a;
  logic signed [ACC_W-1:0] add_b;
  logic                    add_sub;
  logic [ACC_W-1:0]        add_lim;
  logic                    add_on;
  bbq_sat_t                add_res;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    add_lim = ACC_MAX;
    add_on  = 1'b1;
    unique case (ctrl.state)
      ST_PST: begin
        add_b   = signed'(t_r);
        add_sub = neg_r;
        add_lim = DLIM;
      end
      ST_AMA: begin
        add_a = d1x;
        add_b = d1x;
      end
      ST_W1: begin
        add_a   = sq;
        add_b   = signed'(t_r);
        add_sub = !neg_r;
      end
      ST_W2: begin
        add_a   = acc_r;
        add_b   = signed'(t_r);
        add_sub = !neg_r;
        add_lim = DLIM;
      end
      ST_S1: begin
        add_a = acc_r;
        add_b = dd_r;
      end
      ST_S2: begin
        add_a = acc_r;
        add_b = d2x;
      end
      ST_RND: begin
        add_a   = HALF;
        add_b   = signed'(t_r);
        add_sub = neg_r;
      end
      default: add_on = 1'b0;
    endcase
    add_res = bbq_addsub(add_a, add_b, add_sub, add_lim);
  end

  // Delay state and clip flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r   <= '0;
      d2_r   <= '0;
      clip_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        clip_r <= 1'b0;
      end else if ((add_on && add_res.clip) || (is_m2 && t_clip)) begin
        clip_r <= 1'b1;
      end
      if (ctrl.state == ST_PST) begin
        d1_r <= DELAY_BITS'(add_res.val);
        d2_r <= DELAY_BITS'(add_res.val);
      end else if (ctrl.state == ST_S2) begin
        d2_r <= d1_r;
        d1_r <= w_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_r <= sample;
    end
    if (is_ma) begin
      mag_r  <= mul_mag;
      cmag_r <= mul_c;
      neg_r  <= mul_v[ACC_W-1] ^ mul_cneg;
    end
    if (is_m0 || is_m1) begin
      prod_r <= (2*COEF_W)'(mul_chunk) * (2*COEF_W)'(cmag_r);
    end
    if (is_m1) begin
      lo_r <= prod_r;
    end
    if (is_m2) begin
      t_r <= t_clip ? ACC_MAX : t_val;
    end
    if (ctrl.state == ST_AMA) begin
      dd_r <= add_res.val;
    end
    if ((ctrl.state == ST_W1) || (ctrl.state == ST_W2) || (ctrl.state == ST_S1) ||
        (ctrl.state == ST_S2) || (ctrl.state == ST_RND)) begin
      acc_r <= add_res.val;
    end
    if (ctrl.state == ST_W2) begin
      w_r <= DELAY_BITS'(add_res.val);
    end
  end

  // Final value: floor to integer after the rounding half, clip to sample range; the sample itself when not filtering
  logic signed [ACC_W-1:0] y;
  logic                    out_clip;

  always_comb begin
    y        = acc_r >>> DELAY_FRAC;
    out_clip = 1'b0;
    res      = sample_r;
    if (ctrl.filt) begin
      if (y > OUT_HI) begin
        res      = SAMPLE_BITS'(OUT_HI);
        out_clip = 1'b1;
      end else if (y < OUT_LO) begin
        res      = SAMPLE_BITS'(OUT_LO);
        out_clip = 1'b1;
      end else begin
        res = SAMPLE_BITS'(y);
      end
    end
  end

  assign clip = clip_r || out_clip;

endmodule

[rtl/bbq_merge.sv]
// Merge stage: gathers the lane results into the output register and ORs
// the per-lane clip flags. Depends on bbq_pkg and bbq_out_if.
module bbq_merge import bbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] lane_res [AXES],
  input  logic [AXES-1:0]               lane_clip,
  output logic                          free,
  bbq_out_if.source                     out_ch
);

  logic                          valid_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [SAMPLE_BITS-1:0] z_r;
  logic                          sat_r;

  // Slot is free when empty or being drained this cycle
  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      x_r   <= lane_res[0];
      y_r   <= lane_res[1];
      z_r   <= lane_res[2];
      sat_r <= |lane_clip;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_x     = x_r;
  assign out_ch.out_y     = y_r;
  assign out_ch.out_z     = z_r;
  assign out_ch.saturated = sat_r;

endmodule

[bench/butterworth_biquad_three_axis_tb.sv]
// Self-checking bench for the three-axis Butterworth biquad: random and directed
// samples with a bit-exact fixed-point predictor checked against every result.
// Depends on rtl/bbq_pkg.sv, rtl/bbq_if.sv and the butterworth_biquad_three_axis RTL.
module butterworth_biquad_three_axis_tb;
  import bbq_pkg::*;

  localparam logic KIND_FILTER  = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int          SETTLE_CYCLES = 30;

  // Butterworth low-pass at a tenth of the sample rate, Q2.30 / Q8.24
  localparam logic        [31:0] BW_B0   = 32'd72_429_255;
  localparam logic signed [31:0] BW_A1   = -32'sd1_227_265_500;
  localparam logic signed [31:0] BW_A2   = 32'sd443_243_000;
  localparam logic        [31:0] BW_GAIN = 32'd62_179_000;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]           acc_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] out_x;
    logic signed [SAMPLE_BITS_DEF-1:0] out_y;
    logic signed [SAMPLE_BITS_DEF-1:0] out_z;
    logic                              saturated;
  } filtered_t;

  // Tracks filter state and config, predicts each filtered triple, checks results
  class lowpass_tracker;
    logic              enable;
    logic [B0_W-1:0]   b0;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] gain;
    acc_t              first_d[AXES];
    acc_t              second_d[AXES];
    logic              item_clipped;
    filtered_t         pending_filtered[$];
    int                errors;

    function new();
      enable = 0;
      b0     = '0;
      a1     = '0;
      a2     = '0;
      gain   = '0;
      errors = 0;
      foreach (first_d[i]) begin
        first_d[i]  = '0;
        second_d[i] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ENABLE: enable = data[0];
        CFG_B0:     b0     = data[B0_W-1:0];
        CFG_A1:     a1     = data;
        CFG_A2:     a2     = data;
        CFG_GAIN:   gain   = data;
        default: ;
      endcase
    endfunction

    // Symmetric 64-bit saturating add
    function acc_t add_sat(acc_t a, acc_t b);
      logic signed [ACC_W+1:0] s;
      logic signed [ACC_W+1:0] top;
      top = ACC_MAX;
      s   = a;
      s   = s + b;
      if (s > top) begin
        item_clipped = 1'b1;
        return ACC_MAX;
      end
      if (s < -top) begin
        item_clipped = 1'b1;
        return -acc_t'(ACC_MAX);
      end
      return s[ACC_W-1:0];
    endfunction

    // v * (+/-cmag) / 2^sh, magnitude truncated, clipped to the accumulator
    function acc_t scale(acc_t v, logic [32:0] cmag, logic cneg, int sh);
      logic [ACC_W-1:0] mag;
      logic [96:0]      prod;
      logic [96:0]      part;
      acc_t             res;
      logic             neg;
      neg  = v[ACC_W-1] != cneg;
      mag  = v[ACC_W-1] ? ~v + 1'b1 : v;
      prod = {33'b0, mag} * {64'b0, cmag};
      part = prod >> sh;
      if (part > ACC_MAX) begin
        item_clipped = 1'b1;
        part = ACC_MAX;
      end
      res = part[ACC_W-1:0];
      return neg ? -res : res;
    endfunction

    function acc_t times_coef(acc_t v, logic [COEF_W-1:0] raw);
      logic [32:0] cmag;
      cmag = raw[31] ? 33'h1_0000_0000 - {1'b0, raw} : {1'b0, raw};
      return scale(v, cmag, raw[31], SH_COEF);
    endfunction

    function acc_t clip_delay(acc_t v);
      acc_t lim;
      lim = (acc_t'(1) <<< (DELAY_BITS_DEF - 1)) - 1;
      if (v > lim) begin
        item_clipped = 1'b1;
        return lim;
      end
      if (v < -lim) begin
        item_clipped = 1'b1;
        return -lim;
      end
      return v;
    endfunction

    // Round half up to an integer, then clip to the sample range
    function sample_t round_to_sample(acc_t y);
      acc_t r;
      r = add_sat(y, acc_t'(1) <<< (DELAY_FRAC - 1)) >>> DELAY_FRAC;
      if (r > 32767) begin
        item_clipped = 1'b1;
        return 16'sh7FFF;
      end
      if (r < -32768) begin
        item_clipped = 1'b1;
        return 16'sh8000;
      end
      return r[SAMPLE_BITS_DEF-1:0];
    endfunction

    // One axis of direct form II: optional preload, then w and y, delay shift
    function sample_t filter_axis(int ax, sample_t s, logic preload);
      acc_t sq;
      acc_t p;
      acc_t d1;
      acc_t d2;
      acc_t w;
      acc_t acc;
      sq = acc_t'(s) <<< DELAY_FRAC;
      if (preload) begin
        p = clip_delay(scale(sq, {1'b0, gain}, 1'b0, SH_GAIN));
        first_d[ax]  = p;
        second_d[ax] = p;
      end
      if (!enable) return s;
      d1  = first_d[ax];
      d2  = second_d[ax];
      w   = add_sat(sq, -times_coef(d1, a1));
      w   = add_sat(w, -times_coef(d2, a2));
      w   = clip_delay(w);
      acc = add_sat(w, add_sat(d1, d1));
      acc = add_sat(acc, d2);
      acc = scale(acc, {2'b0, b0}, 1'b0, SH_COEF);
      second_d[ax] = d1;
      first_d[ax]  = w;
      return round_to_sample(acc);
    endfunction

    function void take_sample(logic kind, sample_t x, sample_t y, sample_t z);
      filtered_t want;
      item_clipped   = 1'b0;
      want.out_x     = filter_axis(0, x, kind == KIND_PRELOAD);
      want.out_y     = filter_axis(1, y, kind == KIND_PRELOAD);
      want.out_z     = filter_axis(2, z, kind == KIND_PRELOAD);
      want.saturated = item_clipped;
      pending_filtered.push_back(want);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_output(filtered_t got);
      filtered_t want;
      if (pending_filtered.size() == 0) begin
        report("filtered result with no sample pending");
        return;
      end
      want = pending_filtered.pop_front();
      if (got.out_x !== want.out_x)
        report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
      if (got.out_z !== want.out_z)
        report($sformatf("out_z got %0d want %0d", got.out_z, want.out_z));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated got %0b want %0b", got.saturated, want.saturated));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  steady_flow;
  int unsigned           cycles;

  bbq_in_if  in_if();
  bbq_out_if out_if();

  lowpass_tracker tracker = new();

  butterworth_biquad_three_axis i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, off during the steady stretch
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = steady_flow || ($urandom_range(99) >= 7);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_output({out_if.out_x, out_if.out_y, out_if.out_z, out_if.saturated});
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic kind, sample_t x, sample_t y, sample_t z);
    while (!steady_flow && $urandom_range(99) < 7) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.kind     = kind;
    in_if.sample_x = x;
    in_if.sample_y = y;
    in_if.sample_z = z;
    do @(posedge clk); while (!in_if.ready);
    tracker.take_sample(kind, x, y, z);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_coefs(logic [31:0] b0, logic [31:0] a1, logic [31:0] a2,
                             logic [31:0] gain);
    write_reg(CFG_B0, {1'b0, b0[B0_W-1:0]});
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_GAIN, gain);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    in_if.valid = 1'b0;
    while (tracker.pending_filtered.size() != 0) @(negedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Sensor-like noise around a level, now and then a wild sample
  function automatic sample_t near_level(sample_t lvl);
    int v;
    if ($urandom_range(19) == 0) return rand_sample();
    v = lvl;
    v = v + int'($urandom_range(2000)) - 1000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  // Mostly preload followed by a run of samples; the rest lone items of any kind
  task automatic run_random(int count);
    int      n;
    int      run_len;
    sample_t lx;
    sample_t ly;
    sample_t lz;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        lx = rand_sample();
        ly = rand_sample();
        lz = rand_sample();
        run_len = $urandom_range(40, 5);
        send_item(KIND_PRELOAD, lx, ly, lz);
        repeat (run_len) begin
          if ($urandom_range(15) == 0) lx = rand_sample();
          send_item(KIND_FILTER, near_level(lx), near_level(ly), near_level(lz));
        end
        n += run_len + 1;
      end else begin
        send_item(1'($urandom_range(1)), rand_sample(), rand_sample(), rand_sample());
        n++;
      end
    end
  endtask

  // Register settings of the random phases
  task automatic pick_setting(int ph);
    case (ph)
      0, 4: begin
        write_coefs($urandom_range(300_000_000, 1_000_000),
                    32'h0 - $urandom_range(32'h7FFF_FFFF, 32'h0100_0000),
                    $urandom_range(32'h3FFF_FFFF, 0),
                    $urandom_range(32'h0800_0000, 32'h0040_0000));
        write_reg(CFG_ENABLE, 32'd1);
      end
      2: begin
        write_coefs(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        write_reg(CFG_ENABLE, 32'd1);
      end
      3: begin
        write_coefs($urandom, $urandom, $urandom, $urandom);
        write_reg(CFG_ENABLE, 32'd0);
      end
      default: begin
        write_coefs($urandom, $urandom, $urandom, $urandom);
        write_reg(CFG_ENABLE, 32'd1);
      end
    endcase
  endtask

  initial begin
    int ph;
    rst_n          = 1'b0;
    steady_flow    = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENABLE;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_FILTER;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    in_if.sample_z = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Out of reset: disabled pass-through, preload with zero gain
    send_item(KIND_FILTER, 16'sh7FFF, 16'sh8000, 16'sd0);
    send_item(KIND_PRELOAD, 16'sh8000, 16'sh7FFF, 16'sd1);
    send_item(KIND_FILTER, 16'sd1, -16'sd1, 16'sd12345);
    drain();

    // Preload while disabled, then enable and continue from those delays
    write_reg(CFG_GAIN, BW_GAIN);
    send_item(KIND_PRELOAD, 16'sd1000, -16'sd2000, 16'sh7FFF);
    drain();
    write_reg(CFG_B0, BW_B0);
    write_reg(CFG_A1, BW_A1);
    write_reg(CFG_A2, BW_A2);
    write_reg(CFG_ENABLE, 32'd1);
    send_item(KIND_FILTER, 16'sd1000, -16'sd2000, 16'sh7FFF);
    repeat (4) send_item(KIND_FILTER, 16'sh7FFF, 16'sh8000, 16'sd0);
    send_item(KIND_PRELOAD, 16'sh8000, 16'sh7FFF, -16'sd1);
    repeat (3) send_item(KIND_FILTER, 16'sd0, 16'sd0, 16'sd0);
    send_item(KIND_FILTER, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    drain();

    // Unstable, maximal coefficients: growth must end in clipping
    write_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_PRELOAD, 16'sh7FFF, 16'sh8000, 16'sd100);
    repeat (4) send_item(KIND_FILTER, 16'sh8000, 16'sh7FFF, 16'sd0);
    drain();

    // Random phases, the last one without any idling
    for (ph = 0; ph < 6; ph++) begin
      pick_setting(ph);
      steady_flow = (ph == 5);
      run_random(270);
      drain();
    end
    steady_flow = 1'b0;

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
